// ===== src/sha1_pkg.sv =====
package sha1_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_number;
      logic        last_word;
   } rsp_type;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [159:0] INIT_H = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                      32'h10325476, 32'hC3D2E1F0};

   localparam int QDEPTH = 2;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;

endpackage

// ===== src/sha1_message_hasher.sv =====
// SHA-1 message hasher.
// req_ channel: one transaction per message byte (data_byte, byte_valid,
// message_end). A transaction with message_end set closes the message,
// whose byte, if valid, belongs to it; an empty closing transaction is allowed.
// rsp_ channel: five transactions per message, digest words H0..H4 with
// word_number 0..4 and last_word on the fifth.
// A two-entry queue takes request transactions while the engine works.
// The engine takes one byte per cycle while idle; every 64th byte starts a
// compression, one round a cycle, and no byte is taken while it runs.
// The closing transaction pads up to 64 bytes at one byte a cycle and runs
// one or two compressions, then the digest words follow, one per cycle while
// the receiver does not stall.
// While the receiver stalls, the current digest word holds and the engine waits.
// Reset (synchronous) restores the initial chaining value, clears the bit count
// and empties the queue.
module sha1_message_hasher
   import sha1_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    q_valid, q_take;
   req_type q_data;

   sha1_queue u_queue (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall), .in_data(req_data),
      .out_valid(q_valid), .out_take(q_take), .out_data(q_data)
   );

   sha1_engine u_engine (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

// ===== src/sha1_queue.sv =====
module sha1_queue
   import sha1_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_take,
   output req_type out_data
);

   req_type    mem_ff [QDEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'(QDEPTH));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && out_take;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end

endmodule

// ===== src/sha1_engine.sv =====
module sha1_engine
   import sha1_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_take,
   input  req_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_COMP = 3'd1;
   localparam logic [2:0] S_PAD  = 3'd2;
   localparam logic [2:0] S_OUT  = 3'd3;

   logic [2:0]   state_ff, state_in;
   logic [31:0]  wbuf_ff [16];
   logic [31:0]  ws_ff [16];
   logic [159:0] h_ff, h_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [63:0]  bits_ff, bits_in;
   logic [63:0]  len_ff;
   logic [6:0]   rnd_ff, rnd_in;
   logic [5:0]   pos_ff, pos_in;
   logic         fin_ff, fin_in;
   logic         last_ff, last_in;
   logic [2:0]   wn_ff, wn_in;
   logic         wr_en;
   logic [5:0]   wr_pos;
   logic [7:0]   wr_byte;
   logic [31:0]  f, k, w, t, sw;
   logic         start;

   assign cmd_take = (state_ff == S_IDLE) && cmd_valid;

   always_comb begin
      sw = ws_ff[rnd_ff[3:0]];
      if (rnd_ff >= 7'd16) begin
         w = ws_ff[4'(rnd_ff + 7'd13)] ^ ws_ff[4'(rnd_ff + 7'd8)]
           ^ ws_ff[4'(rnd_ff + 7'd2)] ^ sw;
         w = {w[30:0], w[31]};
      end else begin
         w = sw;
      end
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = K0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + w;
   end

   always_comb begin
      state_in = state_ff;
      bits_in  = bits_ff;
      pos_in   = pos_ff;
      rnd_in   = rnd_ff;
      fin_in   = fin_ff;
      last_in  = last_ff;
      wn_in    = wn_ff;
      h_in     = h_ff;
      wr_en    = 1'b0;
      wr_pos   = pos_ff;
      wr_byte  = cmd.data_byte;
      start    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_take) begin
               if (cmd.byte_valid) begin
                  wr_en   = 1'b1;
                  bits_in = bits_ff + 64'd8;
                  pos_in  = pos_ff + 6'd1;
               end
               fin_in = cmd.message_end;
               if (cmd.byte_valid && pos_ff == 6'd63) begin
                  start    = 1'b1;
                  state_in = S_COMP;
               end else if (cmd.message_end) begin
                  state_in = S_PAD;
                  last_in  = 1'b0;
               end
            end
         end
         S_COMP: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd79) begin
               rnd_in = 7'd0;
               h_in = {h_ff[159:128] + t, h_ff[127:96] + a_ff,
                       h_ff[95:64] + {b_ff[1:0], b_ff[31:2]},
                       h_ff[63:32] + c_ff, h_ff[31:0] + d_ff};
               if (!fin_ff) state_in = S_IDLE;
               else if (last_ff) begin
                  state_in = S_OUT;
                  wn_in    = 3'd0;
               end else begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            wr_en  = 1'b1;
            pos_in = pos_ff + 6'd1;
            if (!last_ff && !fin_ff) wr_byte = 8'h00;
            wr_byte = (pos_ff == len_ff[8:3] && !last_ff) ? PAD_BYTE : 8'h00;
            if (pos_ff >= LEN_POS && last_ff)
               wr_byte = 8'(len_ff >> (7'd56 - {pos_ff[2:0], 3'b000}));
            if (pos_ff == 6'd63) begin
               start    = 1'b1;
               state_in = S_COMP;
            end else if (pos_ff == 6'd55 && !last_ff) begin
               last_in = 1'b1;
            end
            if (!last_ff && (pos_ff == len_ff[8:3]) && pos_ff < LEN_POS) last_in = 1'b1;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               wn_in = wn_ff + 3'd1;
               if (wn_ff == 3'd4) begin
                  state_in = S_IDLE;
                  h_in     = INIT_H;
                  bits_in  = 64'd0;
                  pos_in   = 6'd0;
                  fin_in   = 1'b0;
                  last_in  = 1'b0;
                  wn_in    = 3'd0;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = (state_ff == S_OUT);
   always_comb begin
      rsp_data.digest_word = h_ff[159 - 32*wn_ff -: 32];
      rsp_data.word_number = wn_ff;
      rsp_data.last_word   = (wn_ff == 3'd4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bits_ff  <= 64'd0;
         pos_ff   <= 6'd0;
         rnd_ff   <= 7'd0;
         fin_ff   <= 1'b0;
         last_ff  <= 1'b0;
         wn_ff    <= 3'd0;
         h_ff     <= INIT_H;
      end else begin
         state_ff <= state_in;
         bits_ff  <= bits_in;
         pos_ff   <= pos_in;
         rnd_ff   <= rnd_in;
         fin_ff   <= fin_in;
         last_ff  <= last_in;
         wn_ff    <= wn_in;
         h_ff     <= h_in;
      end
      if (cmd_take) len_ff <= bits_in;
      if (wr_en)
         wbuf_ff[wr_pos[5:2]][31 - 8*wr_pos[1:0] -: 8] <= wr_byte;
      if (start) begin
         for (int i = 0; i < 16; i++) ws_ff[i] <= wbuf_ff[i];
         ws_ff[15][7:0] <= wr_byte;
         a_ff <= h_ff[159:128];
         b_ff <= h_ff[127:96];
         c_ff <= h_ff[95:64];
         d_ff <= h_ff[63:32];
         e_ff <= h_ff[31:0];
      end else if (state_ff == S_COMP) begin
         if (rnd_ff >= 7'd16) ws_ff[rnd_ff[3:0]] <= w;
         a_ff <= t;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

endmodule

// ===== src/sha1_checker.sv =====
module sha1_checker
   import sha1_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.word_number <= 3'd4) else $error("word number range");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_number == 3'd4)))
      else $error("last word flag");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_word |=>
      rsp_valid && rsp_data.word_number == $past(rsp_data.word_number) + 3'd1)
      else $error("digest word order");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind sha1_message_hasher sha1_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_data
);

// ===== dv/sha1_message_hasher_test.sv =====
module sha1_message_hasher_test;
   import sha1_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   sha1_message_hasher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   logic [31:0] hash_state [5];
   logic [7:0]  msg_block [64];
   logic [63:0] msg_bits;
   rsp_type     digest_queue [$];
   int          errors = 0;
   int          cycles = 0;
   bit          hold_rsp = 0;
   bit          rsp_random = 1;
   localparam int CYCLE_LIMIT = 400000;

   function automatic logic [31:0] rol(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   task automatic compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, x, t;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
      d = hash_state[3]; e = hash_state[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 16) x = w[r];
         else begin
            x = rol(w[(r+13)&15] ^ w[(r+8)&15] ^ w[(r+2)&15] ^ w[r&15], 1);
            w[r&15] = x;
         end
         if (r < 20) begin f = (b & c) | (~b & d); k = K0; end
         else if (r < 40) begin f = b ^ c ^ d; k = K1; end
         else if (r < 60) begin f = (b & c) | (b & d) | (c & d); k = K2; end
         else begin f = b ^ c ^ d; k = K3; end
         t = rol(a, 5) + f + e + k + x;
         e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
      hash_state[3] += d; hash_state[4] += e;
   endtask

   task automatic restart_hash();
      for (int i = 0; i < 5; i++) hash_state[i] = INIT_H[159-32*i -: 32];
      msg_bits = 64'd0;
   endtask

   task automatic predict_digest(req_type it);
      int pos;
      logic [63:0] len;
      rsp_type r;
      pos = msg_bits[8:3];
      if (it.byte_valid) begin
         msg_block[pos] = it.data_byte;
         msg_bits += 64'd8;
         pos = (pos + 1) & 63;
         if (pos == 0) compress();
      end
      if (!it.message_end) return;
      len = msg_bits;
      msg_block[pos] = PAD_BYTE;
      pos++;
      if (pos > 56) begin
         while (pos < 64) msg_block[pos++] = 8'h00;
         compress();
         pos = 0;
      end
      while (pos < 56) msg_block[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[56+i] = len[63-8*i -: 8];
      compress();
      for (int i = 0; i < 5; i++) begin
         r.digest_word = hash_state[i];
         r.word_number = 3'(i);
         r.last_word = (i == 4);
         digest_queue.push_back(r);
      end
      restart_hash();
   endtask

   task automatic send_byte(logic [7:0] b, bit v, bit e, bit gaps = 1);
      req_type it;
      int g;
      it.data_byte = b; it.byte_valid = v; it.message_end = e;
      g = gaps ? $urandom_range(0, 7) : 0;
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_digest(it);
   endtask

   task automatic wait_drained();
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_message(int n, bit empty_end);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom_range(0, 255)), 1, !empty_end && i == n - 1);
      if (empty_end || n == 0) send_byte(8'($urandom_range(0, 255)), 0, 1);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1;
      else if (rsp_random) rsp_stall <= ($urandom_range(0, 7) < 3);
      else rsp_stall <= 0;
   end

   always @(posedge clock) begin
      rsp_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_queue.size() == 0) begin
            $display("%0t unexpected transaction %h", $time, rsp_data);
            errors++;
         end else begin
            x = digest_queue.pop_front();
            if (x !== rsp_data) begin
               $display("%0t mismatch expected %h actual %h", $time, x, rsp_data);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_byte(8'h00, 0, 1);
      send_byte(8'h61, 1, 0); send_byte(8'h62, 1, 0); send_byte(8'h63, 1, 1);
      send_byte(8'hff, 1, 0); send_byte(8'h00, 0, 0); send_byte(8'h00, 1, 1);
      send_byte(8'h55, 0, 0); send_byte(8'haa, 1, 1);
      req_valid <= 0;
      wait_drained();
   endtask

   task automatic test_boundaries();
      send_message(56, 0);
      send_message(64, 0);
      req_valid <= 0;
      wait_drained();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         begin
            send_message(3, 0);
            for (int i = 0; i < 12; i++) send_byte(8'($urandom), 1, 0, 0);
            send_byte(8'h00, 0, 1, 0);
            req_valid <= 0;
         end
      join
      wait_drained();
   endtask

   task automatic test_random();
      int n;
      for (int m = 0; m < 14; m++) begin
         rsp_random = (m % 4 != 3);
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) send_byte(8'($urandom), 0, 0);
            send_byte(8'($urandom), 1, 0, m % 3 != 0);
         end
         send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1, m % 3 != 0);
      end
      req_valid <= 0;
      rsp_random = 1;
      wait_drained();
   endtask

   initial begin
      restart_hash();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_boundaries();
      test_backpressure();
      test_random();
      repeat (50) @(posedge clock);
      if (errors == 0 && digest_queue.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ===== sha1_message_hasher.f =====
src/sha1_pkg.sv
src/sha1_queue.sv
src/sha1_engine.sv
src/sha1_message_hasher.sv
src/sha1_checker.sv
dv/sha1_message_hasher_test.sv
